FILE: hdl/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types and constants for the sorted adjacency store.
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int NODE_COUNT_DEF    = 256;
  localparam int EDGE_CAPACITY_DEF = 4096;

  localparam int OP_W    = 2;
  localparam int ID_W    = 8;
  localparam int POS_W   = 12;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 13;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LO,
    S_HI,
    S_BS,
    S_BSW,
    S_CHK,
    S_CHKW,
    S_DEC,
    S_SHU,
    S_SHUW,
    S_SHD,
    S_SHDW,
    S_OFFR,
    S_OFFW,
    S_RDW
  } state_t;

endpackage

FILE: hdl/sas_if.sv
// ----------------------------------------------------------------------------
// sas_in_if / sas_out_if
// Valid/ready channels for requests and results of the adjacency store.
// ----------------------------------------------------------------------------
interface sas_in_if;
  logic                         valid;
  logic                         ready;
  logic [sas_pkg::OP_W-1:0]     opcode;
  logic [sas_pkg::ID_W-1:0]     node;
  logic [sas_pkg::ID_W-1:0]     neighbor;
  logic [sas_pkg::POS_W-1:0]    position;

  modport source (output valid, opcode, node, neighbor, position, input ready);
  modport sink   (input valid, opcode, node, neighbor, position, output ready);
endinterface

interface sas_out_if;
  logic                         valid;
  logic                         ready;
  logic [sas_pkg::STAT_W-1:0]   status;
  logic                         found;
  logic [sas_pkg::COUNT_W-1:0]  degree;
  logic [sas_pkg::ID_W-1:0]     neighbor_out;
  logic [sas_pkg::COUNT_W-1:0]  total_edges;

  modport source (output valid, status, found, degree, neighbor_out, total_edges,
                  input ready);
  modport sink   (input valid, status, found, degree, neighbor_out, total_edges,
                  output ready);
endinterface

FILE: hdl/sorted_adjacency_store.sv
// ----------------------------------------------------------------------------
// sorted_adjacency_store
// Graph edges in compressed-sparse-row form with sorted neighbor lists.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_ch (insert, remove, query, read at position);
// exactly one result per request leaves on out_ch. Both are valid/ready.
// The start-offset table and the neighbor store are synchronous RAMs;
// one request is worked at a time by a sequencer.
// Work per request:
//   read   : two offset reads, then a neighbor store read if position is in range
//   query  : two offset reads, then a lower-bound binary search and a check
//   insert/remove : query work, then a shift of all later entries in the
//   single-port neighbor store and an update of the offset table from
//   node+1 up to NODE_COUNT; these two steps set the worst case.
// After reset the offset table is zeroed, entries 0 to NODE_COUNT; in_ch.ready
// stays low during that pass. A finished result sits in the output register;
// while the receiver stalls, one further request is accepted and worked, and
// its result waits until the register frees up.
// ----------------------------------------------------------------------------
module sorted_adjacency_store #(
  parameter int NODE_COUNT    = sas_pkg::NODE_COUNT_DEF,
  parameter int EDGE_CAPACITY = sas_pkg::EDGE_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sas_in_if.sink     in_ch,
  sas_out_if.source  out_ch
);

  localparam int AW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
  localparam int CW = $clog2(EDGE_CAPACITY + 1);
  localparam int NW = $clog2(NODE_COUNT + 1);

  // Memories
  logic [CW-1:0] off_mem [0:NODE_COUNT];
  logic [sas_pkg::ID_W-1:0] edge_mem [0:EDGE_CAPACITY-1];

  logic          off_we;
  logic [NW-1:0] off_wa, off_ra;
  logic [CW-1:0] off_wd, off_q;
  logic          edge_we;
  logic [AW-1:0] edge_wa, edge_ra;
  logic [sas_pkg::ID_W-1:0] edge_wd, edge_q;

  always_ff @(posedge clk) begin
    if (off_we) off_mem[off_wa] <= off_wd;
    off_q <= off_mem[off_ra];
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    edge_q <= edge_mem[edge_ra];
  end

  // Control and datapath registers
  sas_pkg::state_t state_r, state_nxt;
  logic               done_r, done_nxt;
  sas_pkg::op_t       op_r, op_nxt;
  logic [NW-1:0]      node_r, node_nxt;
  logic [sas_pkg::ID_W-1:0]  nb_r, nb_nxt;
  logic [sas_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [CW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0]      bl_r, bl_nxt, bh_r, bh_nxt, mid_r, mid_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt, total_r, total_nxt, deg_r, deg_nxt;
  logic [NW-1:0]      idx_r, idx_nxt;
  logic               found_r, found_nxt;
  sas_pkg::status_t   stat_r, stat_nxt;
  logic [sas_pkg::ID_W-1:0] nout_r, nout_nxt;

  logic               ov_r, ov_nxt;
  sas_pkg::status_t   o_stat_r, o_stat_nxt;
  logic               o_found_r, o_found_nxt;
  logic [CW-1:0]      o_deg_r, o_deg_nxt, o_tot_r, o_tot_nxt;
  logic [sas_pkg::ID_W-1:0] o_nout_r, o_nout_nxt;

  logic [CW-1:0] mid_c;
  logic          up_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sas_pkg::S_CLEAR;
      done_r  <= 1'b0;
      idx_r   <= '0;
      total_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      idx_r   <= idx_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    node_r    <= node_nxt;
    nb_r      <= nb_nxt;
    pos_r     <= pos_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    bl_r      <= bl_nxt;
    bh_r      <= bh_nxt;
    mid_r     <= mid_nxt;
    ptr_r     <= ptr_nxt;
    deg_r     <= deg_nxt;
    found_r   <= found_nxt;
    stat_r    <= stat_nxt;
    nout_r    <= nout_nxt;
    o_stat_r  <= o_stat_nxt;
    o_found_r <= o_found_nxt;
    o_deg_r   <= o_deg_nxt;
    o_tot_r   <= o_tot_nxt;
    o_nout_r  <= o_nout_nxt;
  end

  assign mid_c = bl_r + ((bh_r - bl_r) >> 1);
  assign up_c  = (op_r == sas_pkg::OP_INSERT);

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    op_nxt    = op_r;
    node_nxt  = node_r;
    nb_nxt    = nb_r;
    pos_nxt   = pos_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    bl_nxt    = bl_r;
    bh_nxt    = bh_r;
    mid_nxt   = mid_r;
    ptr_nxt   = ptr_r;
    idx_nxt   = idx_r;
    total_nxt = total_r;
    deg_nxt   = deg_r;
    found_nxt = found_r;
    stat_nxt  = stat_r;
    nout_nxt  = nout_r;
    ov_nxt      = ov_r;
    o_stat_nxt  = o_stat_r;
    o_found_nxt = o_found_r;
    o_deg_nxt   = o_deg_r;
    o_tot_nxt   = o_tot_r;
    o_nout_nxt  = o_nout_r;

    off_we  = 1'b0;
    off_wa  = idx_r;
    off_wd  = '0;
    off_ra  = idx_r;
    edge_we = 1'b0;
    edge_wa = AW'(ptr_r);
    edge_wd = nb_r;
    edge_ra = AW'(mid_c);
    in_ch.ready = 1'b0;

    if (ov_r && out_ch.ready) ov_nxt = 1'b0;

    // Pending result moves to the output register once it is free
    if (done_r && (!ov_r || out_ch.ready)) begin
      done_nxt    = 1'b0;
      ov_nxt      = 1'b1;
      o_stat_nxt  = stat_r;
      o_found_nxt = found_r;
      o_deg_nxt   = deg_r;
      o_tot_nxt   = total_r;
      o_nout_nxt  = nout_r;
    end

    case (state_r)
      sas_pkg::S_CLEAR: begin
        off_we  = 1'b1;
        off_wa  = idx_r;
        off_wd  = '0;
        if (32'(idx_r) == NODE_COUNT) begin
          idx_nxt   = '0;
          state_nxt = sas_pkg::S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      sas_pkg::S_IDLE: begin
        in_ch.ready = !done_r;
        off_ra      = NW'(in_ch.node);
        if (in_ch.valid && !done_r) begin
          op_nxt    = sas_pkg::op_t'(in_ch.opcode);
          node_nxt  = NW'(in_ch.node);
          nb_nxt    = in_ch.neighbor;
          pos_nxt   = in_ch.position;
          found_nxt = 1'b0;
          nout_nxt  = '0;
          stat_nxt  = sas_pkg::ST_DONE;
          if (32'(in_ch.node) >= NODE_COUNT) begin
            stat_nxt = sas_pkg::ST_RANGE;
            deg_nxt  = '0;
            done_nxt = 1'b1;
          end else begin
            state_nxt = sas_pkg::S_LO;
          end
        end
      end
      sas_pkg::S_LO: begin
        lo_nxt    = off_q;
        off_ra    = node_r + 1'b1;
        state_nxt = sas_pkg::S_HI;
      end
      sas_pkg::S_HI: begin
        hi_nxt  = off_q;
        deg_nxt = off_q - lo_r;
        bl_nxt  = lo_r;
        bh_nxt  = off_q;
        edge_ra = AW'(32'(lo_r) + 32'(pos_r));
        if (op_r == sas_pkg::OP_READ) begin
          if (32'(pos_r) >= 32'(off_q - lo_r)) begin
            stat_nxt  = sas_pkg::ST_RANGE;
            done_nxt  = 1'b1;
            state_nxt = sas_pkg::S_IDLE;
          end else begin
            state_nxt = sas_pkg::S_RDW;
          end
        end else begin
          state_nxt = sas_pkg::S_BS;
        end
      end
      sas_pkg::S_RDW: begin
        nout_nxt  = edge_q;
        done_nxt  = 1'b1;
        state_nxt = sas_pkg::S_IDLE;
      end
      // Lower-bound binary search; each probe reads the middle entry, then narrows
      sas_pkg::S_BS: begin
        edge_ra = AW'(mid_c);
        mid_nxt = mid_c;
        if (bl_r < bh_r) state_nxt = sas_pkg::S_BSW;
        else             state_nxt = sas_pkg::S_CHK;
      end
      sas_pkg::S_BSW: begin
        if (edge_q < nb_r) bl_nxt = mid_r + 1'b1;
        else               bh_nxt = mid_r;
        state_nxt = sas_pkg::S_BS;
      end
      sas_pkg::S_CHK: begin
        edge_ra = AW'(bl_r);
        if (bl_r < hi_r) begin
          state_nxt = sas_pkg::S_CHKW;
        end else begin
          found_nxt = 1'b0;
          state_nxt = sas_pkg::S_DEC;
        end
      end
      sas_pkg::S_CHKW: begin
        found_nxt = (edge_q == nb_r);
        state_nxt = sas_pkg::S_DEC;
      end
      sas_pkg::S_DEC: begin
        idx_nxt = node_r + 1'b1;
        case (op_r)
          sas_pkg::OP_INSERT: begin
            if (found_r) begin
              stat_nxt  = sas_pkg::ST_PRESENT;
              done_nxt  = 1'b1;
              state_nxt = sas_pkg::S_IDLE;
            end else if (32'(total_r) >= EDGE_CAPACITY) begin
              stat_nxt  = sas_pkg::ST_FULL;
              done_nxt  = 1'b1;
              state_nxt = sas_pkg::S_IDLE;
            end else begin
              ptr_nxt   = total_r;
              state_nxt = sas_pkg::S_SHU;
            end
          end
          sas_pkg::OP_REMOVE: begin
            if (!found_r) begin
              stat_nxt  = sas_pkg::ST_NOT_FOUND;
              done_nxt  = 1'b1;
              state_nxt = sas_pkg::S_IDLE;
            end else begin
              ptr_nxt   = bl_r;
              state_nxt = sas_pkg::S_SHD;
            end
          end
          default: begin
            stat_nxt  = found_r ? sas_pkg::ST_DONE : sas_pkg::ST_NOT_FOUND;
            done_nxt  = 1'b1;
            state_nxt = sas_pkg::S_IDLE;
          end
        endcase
      end
      // Insert: move entries [at, total) up by one, top first
      sas_pkg::S_SHU: begin
        edge_ra = AW'(ptr_r - 1'b1);
        if (ptr_r > bl_r) begin
          state_nxt = sas_pkg::S_SHUW;
        end else begin
          edge_we   = 1'b1;
          edge_wa   = AW'(bl_r);
          edge_wd   = nb_r;
          state_nxt = sas_pkg::S_OFFR;
        end
      end
      sas_pkg::S_SHUW: begin
        edge_we   = 1'b1;
        edge_wa   = AW'(ptr_r);
        edge_wd   = edge_q;
        ptr_nxt   = ptr_r - 1'b1;
        state_nxt = sas_pkg::S_SHU;
      end
      // Remove: move entries (at, total) down by one
      sas_pkg::S_SHD: begin
        edge_ra = AW'(ptr_r + 1'b1);
        if ((ptr_r + 1'b1) < total_r) state_nxt = sas_pkg::S_SHDW;
        else                         state_nxt = sas_pkg::S_OFFR;
      end
      sas_pkg::S_SHDW: begin
        edge_we   = 1'b1;
        edge_wa   = AW'(ptr_r);
        edge_wd   = edge_q;
        ptr_nxt   = ptr_r + 1'b1;
        state_nxt = sas_pkg::S_SHD;
      end
      sas_pkg::S_OFFR: begin
        off_ra    = idx_r;
        state_nxt = sas_pkg::S_OFFW;
      end
      sas_pkg::S_OFFW: begin
        off_we = 1'b1;
        off_wa = idx_r;
        off_wd = up_c ? off_q + 1'b1 : off_q - 1'b1;
        if (32'(idx_r) == NODE_COUNT) begin
          total_nxt = up_c ? total_r + 1'b1 : total_r - 1'b1;
          deg_nxt   = up_c ? deg_r + 1'b1 : deg_r - 1'b1;
          stat_nxt  = sas_pkg::ST_DONE;
          done_nxt  = 1'b1;
          state_nxt = sas_pkg::S_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = sas_pkg::S_OFFR;
        end
      end
      default: state_nxt = sas_pkg::S_IDLE;
    endcase
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.status       = o_stat_r;
  assign out_ch.found        = o_found_r;
  assign out_ch.degree       = sas_pkg::COUNT_W'(o_deg_r);
  assign out_ch.neighbor_out = o_nout_r;
  assign out_ch.total_edges  = sas_pkg::COUNT_W'(o_tot_r);

endmodule

FILE: hdl/sas_checker.sv
// ----------------------------------------------------------------------------
// sas_checker
// Port-level checks for the sorted adjacency store, bound to the top level.
// ----------------------------------------------------------------------------
module sas_checker #(
  parameter int EDGE_CAPACITY = sas_pkg::EDGE_CAPACITY_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [sas_pkg::STAT_W-1:0]   out_status,
  input logic                         out_found,
  input logic [sas_pkg::COUNT_W-1:0]  out_degree,
  input logic [sas_pkg::COUNT_W-1:0]  out_total_edges
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_degree) && $stable(out_total_edges))
    else $error("result changed while stalled");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == sas_pkg::ST_FULL |->
      32'(out_total_edges) == EDGE_CAPACITY && !out_found)
    else $error("store full reported below capacity");

  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sas_pkg::ST_PRESENT ||
                  out_status == sas_pkg::ST_NOT_FOUND) |->
      out_found == (out_status == sas_pkg::ST_PRESENT))
    else $error("found flag disagrees with status");

  a_degree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_degree <= out_total_edges)
    else $error("degree exceeds total edges");

  a_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready during clearing pass");

endmodule

bind sorted_adjacency_store sas_checker #(.EDGE_CAPACITY(EDGE_CAPACITY)) u_sas_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found       (out_ch.found),
  .out_degree      (out_ch.degree),
  .out_total_edges (out_ch.total_edges)
);

FILE: tb/sv/tb_sorted_adjacency_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_adjacency_store
// Drives insert, remove, query and read requests into the adjacency store,
// predicts each result from a local model of the edge lists and compares
// every result transfer field by field, in order.
// ----------------------------------------------------------------------------
module tb_sorted_adjacency_store;

  localparam int NODES = sas_pkg::NODE_COUNT_DEF;
  localparam int CAP   = sas_pkg::EDGE_CAPACITY_DEF;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    sas_pkg::status_t                 status;
    logic                             found;
    logic [sas_pkg::COUNT_W-1:0]      degree;
    logic [sas_pkg::ID_W-1:0]         neighbor_out;
    logic [sas_pkg::COUNT_W-1:0]      total_edges;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  sas_in_if  in_ch();
  sas_out_if out_ch();

  sorted_adjacency_store dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  // local copy of the graph
  int unsigned    offs[NODES+1];
  logic [sas_pkg::ID_W-1:0] nbrs[CAP];
  result_t        pending_results[$];
  int             errors = 0;
  longint         cycles = 0;
  bit             idle_on = 1'b1;

  function automatic result_t apply_request(sas_pkg::op_t op, int node,
                                            logic [sas_pkg::ID_W-1:0] nb, int pos);
    result_t r;
    int lo, hi, tot, at, mid;
    bit present;
    lo = offs[node];
    hi = offs[node+1];
    tot = offs[NODES];
    r = '0;
    r.status = sas_pkg::ST_DONE;
    at = lo;
    mid = hi;
    while (at < mid) begin
      if (nbrs[at + (mid - at) / 2] < nb) at = at + (mid - at) / 2 + 1;
      else mid = at + (mid - at) / 2;
    end
    present = (at < hi) && (nbrs[at] == nb);
    case (op)
      sas_pkg::OP_INSERT: begin
        r.found = present;
        if (present) r.status = sas_pkg::ST_PRESENT;
        else if (tot >= CAP) r.status = sas_pkg::ST_FULL;
        else begin
          for (int i = tot; i > at; i--) nbrs[i] = nbrs[i-1];
          nbrs[at] = nb;
          for (int i = node + 1; i <= NODES; i++) offs[i]++;
        end
      end
      sas_pkg::OP_REMOVE: begin
        r.found = present;
        if (!present) r.status = sas_pkg::ST_NOT_FOUND;
        else begin
          for (int i = at; i < tot - 1; i++) nbrs[i] = nbrs[i+1];
          for (int i = node + 1; i <= NODES; i++) offs[i]--;
        end
      end
      sas_pkg::OP_QUERY: begin
        r.found = present;
        r.status = present ? sas_pkg::ST_DONE : sas_pkg::ST_NOT_FOUND;
      end
      default: begin
        if (pos >= hi - lo) r.status = sas_pkg::ST_RANGE;
        else r.neighbor_out = nbrs[lo + pos];
      end
    endcase
    r.degree = sas_pkg::COUNT_W'(offs[node+1] - offs[node]);
    r.total_edges = sas_pkg::COUNT_W'(offs[NODES]);
    return r;
  endfunction

  // valid stays high after a transfer; the next call may drop it, a drain drops it
  task automatic send_request(sas_pkg::op_t op, int node, int nb, int pos);
    while (idle_on && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.node <= sas_pkg::ID_W'(node);
    in_ch.neighbor <= sas_pkg::ID_W'(nb);
    in_ch.position <= sas_pkg::POS_W'(pos);
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_request(op, node, sas_pkg::ID_W'(nb), pos));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checker with random backpressure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: expected none actual status=%0d", $time,
                   out_ch.status);
          errors++;
        end else begin
          result_t e;
          e = pending_results.pop_front();
          if (out_ch.status !== e.status) begin
            $display("%0t status: expected %0d actual %0d", $time, e.status, out_ch.status);
            errors++;
          end
          if (out_ch.found !== e.found) begin
            $display("%0t found: expected %0d actual %0d", $time, e.found, out_ch.found);
            errors++;
          end
          if (out_ch.degree !== e.degree) begin
            $display("%0t degree: expected %0d actual %0d", $time, e.degree, out_ch.degree);
            errors++;
          end
          if (out_ch.neighbor_out !== e.neighbor_out) begin
            $display("%0t neighbor_out: expected %0d actual %0d", $time, e.neighbor_out,
                     out_ch.neighbor_out);
            errors++;
          end
          if (out_ch.total_edges !== e.total_edges) begin
            $display("%0t total_edges: expected %0d actual %0d", $time, e.total_edges,
                     out_ch.total_edges);
            errors++;
          end
        end
      end
      out_ch.ready <= !idle_on || ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_extremes();
    send_request(sas_pkg::OP_READ, 0, 0, 0);
    send_request(sas_pkg::OP_REMOVE, 255, 255, 0);
    send_request(sas_pkg::OP_QUERY, 0, 0, 0);
    send_request(sas_pkg::OP_INSERT, 0, 255, 0);
    send_request(sas_pkg::OP_INSERT, 0, 0, 0);
    send_request(sas_pkg::OP_INSERT, 0, 128, 0);
    send_request(sas_pkg::OP_INSERT, 0, 128, 0);
    send_request(sas_pkg::OP_INSERT, 255, 0, 0);
    send_request(sas_pkg::OP_INSERT, 255, 255, 0);
    send_request(sas_pkg::OP_INSERT, 100, 55, 0);
    send_request(sas_pkg::OP_QUERY, 0, 128, 0);
    send_request(sas_pkg::OP_QUERY, 0, 127, 0);
    send_request(sas_pkg::OP_READ, 0, 0, 2);
    send_request(sas_pkg::OP_READ, 0, 0, 3);
    send_request(sas_pkg::OP_READ, 0, 0, 4095);
    send_request(sas_pkg::OP_READ, 255, 0, 1);
    send_request(sas_pkg::OP_REMOVE, 0, 128, 0);
    send_request(sas_pkg::OP_REMOVE, 0, 128, 0);
    send_request(sas_pkg::OP_REMOVE, 255, 0, 0);
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      int r, node;
      r = $urandom_range(99);
      node = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(7);
      // second quarter runs with no idling on either side
      idle_on = (i < count / 4) || (i >= count / 2);
      if (r < 40) send_request(sas_pkg::OP_INSERT, node, $urandom_range(255), 0);
      else if (r < 60) send_request(sas_pkg::OP_REMOVE, node, $urandom_range(255), 0);
      else if (r < 80) send_request(sas_pkg::OP_QUERY, node, $urandom_range(255), 0);
      else send_request(sas_pkg::OP_READ, node, $urandom_range(255),
                        ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(15));
      if (i == count / 2) begin
        // hold off until the block has drained
        wait_drained();
      end
    end
    idle_on = 1'b1;
  endtask

  // a few requests against the lists built up so far
  task automatic test_spot_checks();
    send_request(sas_pkg::OP_INSERT, 3, 200, 0);
    send_request(sas_pkg::OP_INSERT, 255, 1, 0);
    send_request(sas_pkg::OP_READ, 7, 0, $urandom_range(20));
    send_request(sas_pkg::OP_QUERY, 9, $urandom_range(255), 0);
    send_request(sas_pkg::OP_REMOVE, 1, nbrs[offs[1]], 0);
    send_request(sas_pkg::OP_INSERT, 2, $urandom_range(255), 0);
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.opcode <= sas_pkg::OP_QUERY;
    in_ch.node <= '0;
    in_ch.neighbor <= '0;
    in_ch.position <= '0;
    for (int i = 0; i <= NODES; i++) offs[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_random_mix(115);
    test_spot_checks();
    wait_drained();
    repeat (2 * CAP + 2 * NODES + 50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
